[hdl/pcsv_pkg.sv]
// Shared types, constants and CRC helper for the PNG chunk stream validator.
package pcsv_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic        file_valid;
        logic [2:0]  fault_code;
        logic        dims_valid;
        logic [30:0] image_width;
        logic [30:0] image_height;
    } result_t;

    typedef enum logic [2:0] {
        PH_SIG  = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_DATA = 3'd3,
        PH_CRC  = 3'd4,
        PH_DONE = 3'd5,
        PH_ERR  = 3'd6
    } phase_t;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_SIGNATURE = 3'd1;
    localparam logic [2:0] ERR_TRUNCATED = 3'd2;
    localparam logic [2:0] ERR_CRC       = 3'd3;
    localparam logic [2:0] ERR_IEND_LEN  = 3'd4;
    localparam logic [2:0] ERR_TRAILING  = 3'd5;

    localparam logic [31:0] CRC_POLY  = 32'hedb88320;
    localparam logic [31:0] CRC_INIT  = 32'hffffffff;
    localparam logic [31:0] TYPE_IEND = 32'h49454e44;
    localparam logic [31:0] TYPE_IHDR = 32'h49484452;

    localparam logic [4:0] HDR_TYPE_START   = 5'd12;
    localparam logic [4:0] HDR_WIDTH_START  = 5'd16;
    localparam logic [4:0] HDR_HEIGHT_START = 5'd20;
    localparam logic [4:0] HDR_END          = 5'd24;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h89;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h4e;
            3'd3:    b = 8'h47;
            3'd4:    b = 8'h0d;
            3'd5:    b = 8'h0a;
            3'd6:    b = 8'h1a;
            default: b = 8'h0a;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] ihdr_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h49;
            2'd1:    b = 8'h48;
            2'd2:    b = 8'h44;
            default: b = 8'h52;
        endcase
        return b;
    endfunction

    // Reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

[hdl/pcsv_in_stage.sv]
// Input register stage: holds one byte transfer until the parser consumes it.
module pcsv_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  pcsv_pkg::item_t     src_item,
    input  logic                advance,
    output logic                stage_valid,
    output pcsv_pkg::item_t     stage_item
);

    logic            valid_reg;
    pcsv_pkg::item_t item_reg;

    assign src_stall   = valid_reg && !advance;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || advance)
        begin
            valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && !src_stall)
        begin
            item_reg <= src_item;
        end
    end

endmodule

[hdl/pcsv_parser.sv]
// Chunk parser: signature check, chunk walk, CRC-32, header capture and result build.
module pcsv_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  pcsv_pkg::item_t     item,
    output logic                done,
    output pcsv_pkg::result_t   result
);

    pcsv_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  idx_reg, idx_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] rcv_reg, rcv_next;
    logic [31:0] type_reg, type_next;
    logic [2:0]  err_reg, err_next;
    logic [4:0]  off_reg, off_next;
    logic [31:0] width_reg, width_next;
    logic [31:0] height_reg, height_next;
    logic        ihdr_reg, ihdr_next;

    logic [7:0]  b;
    logic [3:0]  idx_inc;
    logic [31:0] rem_dec;
    logic [31:0] crc_upd;
    logic        ihdr_match;
    logic [2:0]  fail_code;
    logic        fail;
    logic [2:0]  code;
    logic        dims;

    assign b       = item.data_byte;
    assign idx_inc = idx_reg + 4'd1;
    assign rem_dec = rem_reg - 32'd1;
    assign crc_upd = pcsv_pkg::crc_byte(crc_reg, b);
    assign ihdr_match = (b == pcsv_pkg::ihdr_byte(off_reg[1:0]));
    assign done    = step && item.last_byte;

    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        rem_next    = rem_reg;
        crc_next    = crc_reg;
        rcv_next    = rcv_reg;
        type_next   = type_reg;
        err_next    = err_reg;
        off_next    = off_reg;
        width_next  = width_reg;
        height_next = height_reg;
        ihdr_next   = ihdr_reg;
        fail        = 1'b0;
        fail_code   = pcsv_pkg::ERR_NONE;
        code        = pcsv_pkg::ERR_NONE;
        dims        = 1'b0;
        result      = '0;

        // header capture runs regardless of parse state
        if (off_reg < pcsv_pkg::HDR_END)
        begin
            if (off_reg >= pcsv_pkg::HDR_TYPE_START && off_reg < pcsv_pkg::HDR_WIDTH_START)
            begin
                ihdr_next = (off_reg == pcsv_pkg::HDR_TYPE_START) ? ihdr_match
                                                                  : (ihdr_reg && ihdr_match);
            end
            else if (off_reg >= pcsv_pkg::HDR_WIDTH_START
                     && off_reg < pcsv_pkg::HDR_HEIGHT_START)
            begin
                width_next = {width_reg[23:0], b};
            end
            else if (off_reg >= pcsv_pkg::HDR_HEIGHT_START)
            begin
                height_next = {height_reg[23:0], b};
            end
            off_next = off_reg + 5'd1;
        end

        unique case (phase_reg)
            pcsv_pkg::PH_SIG:
            begin
                if (b != pcsv_pkg::sig_byte(idx_reg[2:0]))
                begin
                    fail      = 1'b1;
                    fail_code = pcsv_pkg::ERR_SIGNATURE;
                end
                else if (idx_inc >= 4'd8)
                begin
                    idx_next   = '0;
                    phase_next = pcsv_pkg::PH_LEN;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            pcsv_pkg::PH_LEN:
            begin
                len_next = {len_reg[23:0], b};
                idx_next = idx_inc;
                if (idx_inc >= 4'd4)
                begin
                    idx_next   = '0;
                    crc_next   = pcsv_pkg::CRC_INIT;
                    type_next  = '0;
                    phase_next = pcsv_pkg::PH_TYPE;
                end
            end
            pcsv_pkg::PH_TYPE:
            begin
                type_next = {type_reg[23:0], b};
                crc_next  = crc_upd;
                idx_next  = idx_inc;
                if (idx_inc >= 4'd4)
                begin
                    idx_next   = '0;
                    rem_next   = len_reg;
                    rcv_next   = '0;
                    phase_next = (len_reg == 32'd0) ? pcsv_pkg::PH_CRC : pcsv_pkg::PH_DATA;
                end
            end
            pcsv_pkg::PH_DATA:
            begin
                crc_next = crc_upd;
                rem_next = rem_dec;
                if (rem_dec == 32'd0)
                begin
                    phase_next = pcsv_pkg::PH_CRC;
                end
            end
            pcsv_pkg::PH_CRC:
            begin
                rcv_next = {rcv_reg[23:0], b};
                idx_next = idx_inc;
                if (idx_inc >= 4'd4)
                begin
                    idx_next = '0;
                    if (~crc_reg != rcv_next)
                    begin
                        fail      = 1'b1;
                        fail_code = pcsv_pkg::ERR_CRC;
                    end
                    else if (type_reg == pcsv_pkg::TYPE_IEND)
                    begin
                        if (len_reg != 32'd0)
                        begin
                            fail      = 1'b1;
                            fail_code = pcsv_pkg::ERR_IEND_LEN;
                        end
                        else
                        begin
                            phase_next = pcsv_pkg::PH_DONE;
                        end
                    end
                    else
                    begin
                        len_next   = '0;
                        phase_next = pcsv_pkg::PH_LEN;
                    end
                end
            end
            pcsv_pkg::PH_DONE:
            begin
                fail      = 1'b1;
                fail_code = pcsv_pkg::ERR_TRAILING;
            end
            default:
            begin
                phase_next = pcsv_pkg::PH_ERR;
            end
        endcase

        if (fail)
        begin
            phase_next = pcsv_pkg::PH_ERR;
            if (err_reg == pcsv_pkg::ERR_NONE)
            begin
                err_next = fail_code;
            end
        end

        if (item.last_byte)
        begin
            code = err_next;
            if (err_next == pcsv_pkg::ERR_NONE && phase_next != pcsv_pkg::PH_DONE)
            begin
                code = pcsv_pkg::ERR_TRUNCATED;
            end
            dims = off_next >= pcsv_pkg::HDR_END && ihdr_next
                   && code != pcsv_pkg::ERR_SIGNATURE
                   && width_next != 32'd0 && height_next != 32'd0
                   && !width_next[31] && !height_next[31];

            result.file_valid   = (code == pcsv_pkg::ERR_NONE);
            result.fault_code   = code;
            result.dims_valid   = dims;
            result.image_width  = dims ? width_next[30:0] : '0;
            result.image_height = dims ? height_next[30:0] : '0;

            // file finished: back to the post-reset state
            phase_next  = pcsv_pkg::PH_SIG;
            idx_next    = '0;
            len_next    = '0;
            rem_next    = '0;
            crc_next    = pcsv_pkg::CRC_INIT;
            rcv_next    = '0;
            type_next   = '0;
            err_next    = pcsv_pkg::ERR_NONE;
            off_next    = '0;
            width_next  = '0;
            height_next = '0;
            ihdr_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= pcsv_pkg::PH_SIG;
            idx_reg    <= '0;
            len_reg    <= '0;
            rem_reg    <= '0;
            crc_reg    <= pcsv_pkg::CRC_INIT;
            rcv_reg    <= '0;
            type_reg   <= '0;
            err_reg    <= pcsv_pkg::ERR_NONE;
            off_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            ihdr_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            len_reg    <= len_next;
            rem_reg    <= rem_next;
            crc_reg    <= crc_next;
            rcv_reg    <= rcv_next;
            type_reg   <= type_next;
            err_reg    <= err_next;
            off_reg    <= off_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            ihdr_reg   <= ihdr_next;
        end
    end

endmodule

[hdl/pcsv_out_stage.sv]
// Result register: holds one result transfer until the sink takes it.
module pcsv_out_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  pcsv_pkg::result_t   load_result,
    output logic                free,
    output logic                res_valid,
    input  logic                res_stall,
    output pcsv_pkg::result_t   res_item
);

    logic              valid_reg;
    pcsv_pkg::result_t result_reg;

    assign free      = !valid_reg || !res_stall;
    assign res_valid = valid_reg;
    assign res_item  = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

endmodule

[hdl/png_chunk_stream_validator_core.sv]
// Top level of the PNG chunk stream validator: input register, parser, result register.
// res_valid comes from the result register, loaded when the parser takes a last byte.
// Throughput: one byte per cycle unless stalled; bytewise CRC-32 is in the parser stage.
// A result waiting under res_stall holds the parser only when a last byte arrives.
// Reset (rst_n low, async) clears all parse state; the block accepts bytes right after.
module png_chunk_stream_validator_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  pcsv_pkg::item_t     src_item,
    output logic                res_valid,
    input  logic                res_stall,
    output pcsv_pkg::result_t   res_item
);

    logic              stage_valid;
    pcsv_pkg::item_t   stage_item;
    logic              advance;
    logic              out_free;
    logic              res_load;
    pcsv_pkg::result_t parse_result;

    // a byte that completes a file needs a free result slot
    assign advance = stage_valid && (!stage_item.last_byte || out_free);

    pcsv_in_stage u_in_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (src_valid),
        .src_stall   (src_stall),
        .src_item    (src_item),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    pcsv_parser u_parser
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (stage_item),
        .done   (res_load),
        .result (parse_result)
    );

    pcsv_out_stage u_out_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (res_load),
        .load_result (parse_result),
        .free        (out_free),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_item    (res_item)
    );

    a_valid_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_item.file_valid == (res_item.fault_code == pcsv_pkg::ERR_NONE)))
        else $error("file_valid disagrees with fault code");

    a_dims_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_item.dims_valid) |->
            (res_item.image_width == '0 && res_item.image_height == '0))
        else $error("dimensions nonzero without dims_valid");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid && stage_item.last_byte && advance) |=> res_valid)
        else $error("completed file produced no result");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_item.fault_code <= pcsv_pkg::ERR_TRAILING))
        else $error("fault code out of range");

endmodule

[tb/tb.sv]
// Self-checking testbench for png_chunk_stream_validator_core against a parser model.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] octets_t[$];

    localparam logic [63:0] PNG_MAGIC     = 64'h89504e470d0a1a0a;
    localparam logic [31:0] DIM_LIMIT     = 32'h7fffffff;
    localparam logic [31:0] KIND_TEXT     = 32'h74455874;
    localparam logic [31:0] KIND_IDAT     = 32'h49444154;
    localparam int          QUIET_LIMIT   = 2000;
    localparam int          PHASE_BYTES   = 170;
    localparam int          SETTLE_CYCLES = 20;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              src_valid = 1'b0;
    logic              src_stall;
    pcsv_pkg::item_t   src_item  = '0;
    logic              res_valid;
    logic              res_stall = 1'b0;
    pcsv_pkg::result_t res_item;

    pcsv_pkg::item_t   pend_q[$];
    pcsv_pkg::result_t verdict_q[$];
    int      idle_pct     = 0;
    int      stall_pct    = 0;
    int      fail_cnt     = 0;
    int      quiet_cycles = 0;

    // parser model state
    pcsv_pkg::phase_t pm_phase;
    logic [3:0]  pm_idx;
    logic [31:0] pm_len;
    logic [31:0] pm_left;
    logic [31:0] pm_crc;
    logic [31:0] pm_crc_rx;
    logic [31:0] pm_type;
    logic [2:0]  pm_err;
    logic [4:0]  pm_hdr;
    logic [31:0] pm_w;
    logic [31:0] pm_h;
    logic        pm_ihdr;

    png_chunk_stream_validator_core u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    always #10 clk = ~clk;

    function automatic logic [31:0] crc32_update(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        repeat (8)
        begin
            if (c[0])
                c = {1'b0, c[31:1]} ^ pcsv_pkg::CRC_POLY;
            else
                c = {1'b0, c[31:1]};
        end
        return c;
    endfunction

    function automatic void parser_clear();
        pm_phase  = pcsv_pkg::PH_SIG;
        pm_idx    = '0;
        pm_len    = '0;
        pm_left   = '0;
        pm_crc    = pcsv_pkg::CRC_INIT;
        pm_crc_rx = '0;
        pm_type   = '0;
        pm_err    = pcsv_pkg::ERR_NONE;
        pm_hdr    = '0;
        pm_w      = '0;
        pm_h      = '0;
        pm_ihdr   = 1'b0;
    endfunction

    function automatic void parser_fail(logic [2:0] code);
        if (pm_err == pcsv_pkg::ERR_NONE)
            pm_err = code;
        pm_phase = pcsv_pkg::PH_ERR;
    endfunction

    // Advances the model by one byte; queues the file verdict on the last byte.
    function automatic void parse_png_byte(pcsv_pkg::item_t it);
        logic [7:0]        b;
        logic              hit;
        int                pos;
        pcsv_pkg::result_t r;
        b = it.data_byte;
        // header capture keeps running after an error
        if (pm_hdr < pcsv_pkg::HDR_END)
        begin
            if (pm_hdr >= pcsv_pkg::HDR_TYPE_START && pm_hdr < pcsv_pkg::HDR_WIDTH_START)
            begin
                pos = 15 - int'(pm_hdr);
                hit = (b == pcsv_pkg::TYPE_IHDR[8*pos +: 8]);
                pm_ihdr = (pm_hdr == pcsv_pkg::HDR_TYPE_START) ? hit : (pm_ihdr && hit);
            end
            else if (pm_hdr >= pcsv_pkg::HDR_WIDTH_START
                     && pm_hdr < pcsv_pkg::HDR_HEIGHT_START)
                pm_w = {pm_w[23:0], b};
            else if (pm_hdr >= pcsv_pkg::HDR_HEIGHT_START)
                pm_h = {pm_h[23:0], b};
            pm_hdr = pm_hdr + 5'd1;
        end
        case (pm_phase)
            pcsv_pkg::PH_SIG:
            begin
                pos = 7 - int'(pm_idx[2:0]);
                if (b != PNG_MAGIC[8*pos +: 8])
                    parser_fail(pcsv_pkg::ERR_SIGNATURE);
                else if (pm_idx == 4'd7)
                begin
                    pm_idx   = '0;
                    pm_phase = pcsv_pkg::PH_LEN;
                end
                else
                    pm_idx = pm_idx + 4'd1;
            end
            pcsv_pkg::PH_LEN:
            begin
                pm_len = {pm_len[23:0], b};
                if (pm_idx == 4'd3)
                begin
                    pm_idx   = '0;
                    pm_crc   = pcsv_pkg::CRC_INIT;
                    pm_type  = '0;
                    pm_phase = pcsv_pkg::PH_TYPE;
                end
                else
                    pm_idx = pm_idx + 4'd1;
            end
            pcsv_pkg::PH_TYPE:
            begin
                pm_type = {pm_type[23:0], b};
                pm_crc  = crc32_update(pm_crc, b);
                if (pm_idx == 4'd3)
                begin
                    pm_idx    = '0;
                    pm_left   = pm_len;
                    pm_crc_rx = '0;
                    pm_phase  = (pm_len == 32'd0) ? pcsv_pkg::PH_CRC : pcsv_pkg::PH_DATA;
                end
                else
                    pm_idx = pm_idx + 4'd1;
            end
            pcsv_pkg::PH_DATA:
            begin
                pm_crc  = crc32_update(pm_crc, b);
                pm_left = pm_left - 32'd1;
                if (pm_left == 32'd0)
                    pm_phase = pcsv_pkg::PH_CRC;
            end
            pcsv_pkg::PH_CRC:
            begin
                pm_crc_rx = {pm_crc_rx[23:0], b};
                if (pm_idx == 4'd3)
                begin
                    pm_idx = '0;
                    if (~pm_crc != pm_crc_rx)
                        parser_fail(pcsv_pkg::ERR_CRC);
                    else if (pm_type == pcsv_pkg::TYPE_IEND)
                    begin
                        if (pm_len != 32'd0)
                            parser_fail(pcsv_pkg::ERR_IEND_LEN);
                        else
                            pm_phase = pcsv_pkg::PH_DONE;
                    end
                    else
                    begin
                        pm_len   = '0;
                        pm_phase = pcsv_pkg::PH_LEN;
                    end
                end
                else
                    pm_idx = pm_idx + 4'd1;
            end
            pcsv_pkg::PH_DONE:
                parser_fail(pcsv_pkg::ERR_TRAILING);
            default:
                pm_phase = pcsv_pkg::PH_ERR;
        endcase
        if (it.last_byte)
        begin
            if (pm_err == pcsv_pkg::ERR_NONE && pm_phase != pcsv_pkg::PH_DONE)
                pm_err = pcsv_pkg::ERR_TRUNCATED;
            r.fault_code   = pm_err;
            r.file_valid   = (pm_err == pcsv_pkg::ERR_NONE);
            r.dims_valid   = pm_hdr >= pcsv_pkg::HDR_END && pm_ihdr &&
                             pm_err != pcsv_pkg::ERR_SIGNATURE &&
                             pm_w != 32'd0 && pm_h != 32'd0 &&
                             pm_w <= DIM_LIMIT && pm_h <= DIM_LIMIT;
            r.image_width  = r.dims_valid ? pm_w[30:0] : '0;
            r.image_height = r.dims_valid ? pm_h[30:0] : '0;
            verdict_q.push_back(r);
            parser_clear();
        end
    endfunction

    // ---------------- stimulus building ----------------

    task automatic put_byte(input logic [7:0] b);
        pcsv_pkg::item_t t;
        t.data_byte = b;
        t.last_byte = 1'b0;
        pend_q.push_back(t);
    endtask

    task automatic put_word(input logic [31:0] v);
        for (int i = 3; i >= 0; i--)
            put_byte(v[8*i +: 8]);
    endtask

    task automatic end_file();
        pcsv_pkg::item_t t;
        t = pend_q.pop_back();
        t.last_byte = 1'b1;
        pend_q.push_back(t);
    endtask

    task automatic put_signature(input bit corrupt);
        logic [63:0] s;
        s = PNG_MAGIC;
        if (corrupt)
            s = s ^ (64'd1 << $urandom_range(63));
        for (int i = 7; i >= 0; i--)
            put_byte(s[8*i +: 8]);
    endtask

    task automatic rand_body(output octets_t q, input int n);
        q.delete();
        repeat (n)
            q.push_back(8'($urandom_range(255)));
    endtask

    task automatic put_chunk(input logic [31:0] kind, input logic [31:0] len_field,
                             input octets_t body, input bit bad_crc);
        logic [31:0] c;
        c = pcsv_pkg::CRC_INIT;
        put_word(len_field);
        put_word(kind);
        for (int i = 3; i >= 0; i--)
            c = crc32_update(c, kind[8*i +: 8]);
        foreach (body[i])
        begin
            put_byte(body[i]);
            c = crc32_update(c, body[i]);
        end
        if (bad_crc)
            c = c ^ (32'd1 << $urandom_range(31));
        put_word(~c);
    endtask

    task automatic put_ihdr(input logic [31:0] w, input logic [31:0] h, input bit bad_crc);
        octets_t body;
        for (int i = 3; i >= 0; i--)
            body.push_back(w[8*i +: 8]);
        for (int i = 3; i >= 0; i--)
            body.push_back(h[8*i +: 8]);
        repeat (5)
            body.push_back(8'($urandom_range(255)));
        put_chunk(pcsv_pkg::TYPE_IHDR, 32'd13, body, bad_crc);
    endtask

    task automatic put_iend(input bit bad_crc);
        octets_t none;
        put_chunk(pcsv_pkg::TYPE_IEND, 32'd0, none, bad_crc);
    endtask

    function automatic logic [31:0] pick_dim();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return DIM_LIMIT;
            3:       return 32'h80000000;
            4:       return 32'hffffffff;
            5:       return $urandom;
            default: return 32'($urandom_range(1, 4096));
        endcase
    endfunction

    function automatic logic [31:0] pick_kind();
        case ($urandom_range(7))
            0:       return pcsv_pkg::TYPE_IHDR;
            1:       return pcsv_pkg::TYPE_IEND;
            2:       return KIND_IDAT;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed files with random content; a few broken ones.
    task automatic gen_file();
        octets_t body;
        int      start;
        int      cut;
        int      r;
        start = pend_q.size();
        put_signature($urandom_range(99) < 4);
        if ($urandom_range(3) != 0)
            put_ihdr(pick_dim(), pick_dim(), $urandom_range(99) < 4);
        repeat ($urandom_range(3))
        begin
            rand_body(body, $urandom_range(6));
            put_chunk(pick_kind(), 32'(body.size()), body, $urandom_range(99) < 4);
        end
        r = $urandom_range(99);
        if (r < 5)
        begin
            rand_body(body, $urandom_range(1, 4));
            put_chunk(pcsv_pkg::TYPE_IEND, 32'(body.size()), body, 1'b0);
        end
        else if (r < 9)
        begin
            // length runs past the end of the file
            rand_body(body, $urandom_range(3));
            put_chunk(pick_kind(), 32'hffff0000 | $urandom_range(65535), body, 1'b0);
        end
        else
            put_iend($urandom_range(99) < 4);
        if ($urandom_range(99) < 5)
            repeat ($urandom_range(1, 3))
                put_byte(8'($urandom_range(255)));
        if ($urandom_range(99) < 6)
        begin
            cut = $urandom_range(start + 1, pend_q.size());
            while (pend_q.size() > cut)
                void'(pend_q.pop_back());
        end
        end_file();
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pend_q.size() != 0 || src_valid || verdict_q.size() != 0);
    endtask

    task automatic put_directed();
        octets_t body;
        put_signature(1'b0); put_ihdr(32'd1, 32'd1, 1'b0); put_iend(1'b0); end_file();
        put_signature(1'b0); put_ihdr(DIM_LIMIT, DIM_LIMIT, 1'b0); put_iend(1'b0); end_file();
        put_signature(1'b0); put_ihdr(32'h80000000, 32'hffffffff, 1'b0); put_iend(1'b0);
        end_file();
        put_signature(1'b0); put_ihdr(32'd0, 32'd7, 1'b0); put_iend(1'b0); end_file();
        // bad signature, single byte and mid-signature
        put_byte(8'h00); end_file();
        put_byte(8'h89); put_byte(8'hff); put_byte(8'h4e); end_file();
        // signature only: truncated
        put_signature(1'b0); end_file();
        // zero-length chunk then IEND
        put_signature(1'b0); put_chunk(KIND_TEXT, 32'd0, body, 1'b0); put_iend(1'b0);
        end_file();
        // CRC error on IHDR, header still captured
        put_signature(1'b0); put_ihdr(32'd640, 32'd480, 1'b1); put_iend(1'b0); end_file();
        // IEND with data and a good CRC
        put_signature(1'b0); put_ihdr(32'd3, 32'd5, 1'b0);
        rand_body(body, 3); put_chunk(pcsv_pkg::TYPE_IEND, 32'd3, body, 1'b0); end_file();
        // IEND with bad CRC
        put_signature(1'b0); put_ihdr(32'd2, 32'd2, 1'b0); put_iend(1'b1); end_file();
        // trailing byte after IEND
        put_signature(1'b0); put_ihdr(32'd9, 32'd9, 1'b0); put_iend(1'b0); put_byte(8'hff);
        end_file();
        // oversized length, file ends inside data
        put_signature(1'b0); rand_body(body, 2);
        put_chunk(KIND_IDAT, 32'hfffffff0, body, 1'b0); end_file();
        // ends after a complete non-IEND chunk
        body.delete();
        body.push_back(8'hff); body.push_back(8'h00);
        body.push_back(8'h55); body.push_back(8'haa);
        put_signature(1'b0); put_ihdr(32'd4, 32'd4, 1'b0);
        put_chunk(KIND_IDAT, 32'd4, body, 1'b0);
        end_file();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 49; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 49; end
                default: begin idle_pct = 12; stall_pct = 12; end
            endcase
            if (p == 0)
                put_directed();
            while (pend_q.size() < PHASE_BYTES)
                gen_file();
            // sender holds off until every verdict is back
            wait_drained();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_cnt == 0 && verdict_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // ---------------- driver, receiver, monitor ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            src_item  <= '0;
        end
        else if (!src_valid || !src_stall)
        begin
            if (pend_q.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                src_valid <= 1'b1;
                src_item  <= pend_q.pop_front();
            end
            else
                src_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
            res_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        pcsv_pkg::result_t want;
        if (!rst_n)
            parser_clear();
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected result transfer: %p", res_item);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (res_item.file_valid   !== want.file_valid   ||
                        res_item.fault_code   !== want.fault_code   ||
                        res_item.dims_valid   !== want.dims_valid   ||
                        res_item.image_width  !== want.image_width  ||
                        res_item.image_height !== want.image_height)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display({"mismatch exp/act: valid %0b/%0b code %0d/%0d",
                                      " dims %0b/%0b w %0d/%0d h %0d/%0d"},
                                     want.file_valid, res_item.file_valid,
                                     want.fault_code, res_item.fault_code,
                                     want.dims_valid, res_item.dims_valid,
                                     want.image_width, res_item.image_width,
                                     want.image_height, res_item.image_height);
                    end
                end
            end
            if (src_valid && !src_stall)
                parse_png_byte(src_item);
            if ((src_valid && !src_stall) || (res_valid && !res_stall))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("FAILED: results differ");
                    $finish;
                end
            end
        end
    end

endmodule

[sim.f]
hdl/pcsv_pkg.sv
hdl/pcsv_in_stage.sv
hdl/pcsv_parser.sv
hdl/pcsv_out_stage.sv
hdl/png_chunk_stream_validator_core.sv
tb/tb.sv
